// ===== hdl/nkls_pkg.sv =====
// Shared widths, register indexes and mode codes for the nearest light selector.
`default_nettype none

package nkls_pkg;

  // Field widths of the transaction payloads.
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned DIST_OUT_W = 52;

  // Magnitude of one axis delta fits 24 bits, its square 48, and three squares 50.
  localparam int unsigned MAG_W  = COORD_W;
  localparam int unsigned PROD_W = 2 * MAG_W;
  localparam int unsigned DIST_W = PROD_W + 2;

  // Default list depth.
  localparam int unsigned KEPT_MAX_DEF = 6;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Z = 2'd2;

  // Command codes on the mode field.
  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Axis selector codes for the shared squaring unit.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage : nkls_pkg

`default_nettype wire

// ===== hdl/nearest_k_light_select.sv =====
// Top level: keeps the KEPT_MAX lights nearest to the viewer, sorted by squared distance.
// An offer passes three times through one shared 24x24 squaring unit (difference, multiply,
// accumulate), then scans with one comparator, one entry a cycle, stopping at most past the n
// stored entries, and then inserts. A flush of n entries emits one registered result a cycle;
// an empty flush emits nothing and stays idle. Results cannot be stalled by the receiver.
// Reset clears the sequencer, entry count and viewer registers, but not the list entries.
`default_nettype none

module nearest_k_light_select #(
  parameter int unsigned KEPT_MAX = nkls_pkg::KEPT_MAX_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write channel.
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [nkls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [nkls_pkg::COORD_W-1:0]        cfg_data_i,
  // Command channel.
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                mode_i,
  input  wire logic [nkls_pkg::ID_W-1:0]           light_id_i,
  input  wire logic signed [nkls_pkg::COORD_W-1:0] center_x_i,
  input  wire logic signed [nkls_pkg::COORD_W-1:0] center_y_i,
  input  wire logic signed [nkls_pkg::COORD_W-1:0] center_z_i,
  // Result channel.
  output logic                                     result_valid_o,
  output logic [nkls_pkg::SLOT_W-1:0]              slot_index_o,
  output logic [nkls_pkg::ID_W-1:0]                kept_light_o,
  output logic [nkls_pkg::DIST_OUT_W-1:0]          dist_squared_o,
  output logic                                     last_of_run_o
);

  import nkls_pkg::*;

  localparam int unsigned CNT_W = $clog2(KEPT_MAX + 1);
  localparam int unsigned IDX_W = (KEPT_MAX > 1) ? $clog2(KEPT_MAX) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_SCAN,
    ST_INSERT,
    ST_FLUSH
  } state_e;

  // Control registers.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [1:0]       axis_q, axis_d;
  logic             res_valid_q, res_valid_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [ID_W-1:0]       kept_q, kept_d;
  logic [DIST_OUT_W-1:0] dist_out_q, dist_out_d;
  logic                  last_q, last_d;

  // Viewer registers.
  logic signed [COORD_W-1:0] vx_q, vx_d;
  logic signed [COORD_W-1:0] vy_q, vy_d;
  logic signed [COORD_W-1:0] vz_q, vz_d;

  // Datapath registers, no reset needed.
  logic [ID_W-1:0]           id_q, id_d;
  logic signed [COORD_W-1:0] cx_q, cx_d;
  logic signed [COORD_W-1:0] cy_q, cy_d;
  logic signed [COORD_W-1:0] cz_q, cz_d;
  logic [MAG_W-1:0]          mag_q, mag_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [DIST_W-1:0]         acc_q, acc_d;
  logic [ID_W-1:0]           ids_q [KEPT_MAX];
  logic [ID_W-1:0]           ids_d [KEPT_MAX];
  logic [DIST_W-1:0]         dists_q [KEPT_MAX];
  logic [DIST_W-1:0]         dists_d [KEPT_MAX];

  // Operands of the shared unit and the single list read port.
  logic signed [COORD_W-1:0] sel_c, sel_v;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          diff_neg;
  logic [ID_W-1:0]           rd_id;
  logic [DIST_W-1:0]         rd_dist;
  logic [CNT_W-1:0]          idx_inc;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);

  assign result_valid_o = res_valid_q;
  assign slot_index_o   = slot_q;
  assign kept_light_o   = kept_q;
  assign dist_squared_o = dist_out_q;
  assign last_of_run_o  = last_q;

  assign rd_id   = ids_q[idx_q[IDX_W-1:0]];
  assign rd_dist = dists_q[idx_q[IDX_W-1:0]];
  assign idx_inc = idx_q + CNT_W'(1);

  // Axis selection for the difference step.
  always_comb begin
    case (axis_q)
      AXIS_X: begin
        sel_c = cx_q;
        sel_v = vx_q;
      end
      AXIS_Y: begin
        sel_c = cy_q;
        sel_v = vy_q;
      end
      AXIS_Z: begin
        sel_c = cz_q;
        sel_v = vz_q;
      end
      default: begin
        sel_c = cx_q;
        sel_v = vx_q;
      end
    endcase
  end

  // Absolute difference; the magnitude never exceeds 2^24 - 1.
  assign diff     = {sel_c[COORD_W-1], sel_c} - {sel_v[COORD_W-1], sel_v};
  assign diff_neg = -diff;

  // Sequencer and next-state logic.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    axis_d      = axis_q;
    res_valid_d = 1'b0;
    slot_d      = slot_q;
    kept_d      = kept_q;
    dist_out_d  = dist_out_q;
    last_d      = last_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    vz_d        = vz_q;
    id_d        = id_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    ids_d       = ids_q;
    dists_d     = dists_q;

    // Configuration writes; indexes past the last register are dropped.
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_VIEWER_X: vx_d = cfg_data_i;
        REG_VIEWER_Y: vy_d = cfg_data_i;
        REG_VIEWER_Z: vz_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start && !busy) begin
          if (mode_i == MODE_FLUSH) begin
            // An empty list flushes with no result.
            if (count_q != '0) begin
              idx_d   = '0;
              state_d = ST_FLUSH;
            end
          end else begin
            id_d    = light_id_i;
            cx_d    = center_x_i;
            cy_d    = center_y_i;
            cz_d    = center_z_i;
            axis_d  = AXIS_X;
            acc_d   = '0;
            state_d = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        mag_d   = diff[COORD_W] ? MAG_W'(diff_neg) : MAG_W'(diff);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = mag_q * mag_q;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q + DIST_W'(prod_q);
        if (axis_q == AXIS_Z) begin
          idx_d   = '0;
          state_d = ST_SCAN;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_DIFF;
        end
      end
      ST_SCAN: begin
        // Stop at the first entry strictly farther, or past the last entry.
        if (idx_q == count_q || rd_dist > acc_q) begin
          state_d = ST_INSERT;
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_INSERT: begin
        // Shift the tail down one place and drop the farthest when full.
        if (idx_q < CNT_W'(KEPT_MAX)) begin
          for (int i = 1; i < KEPT_MAX; i++) begin
            if (CNT_W'(i) > idx_q) begin
              ids_d[i]   = ids_q[i-1];
              dists_d[i] = dists_q[i-1];
            end
          end
          ids_d[idx_q[IDX_W-1:0]]   = id_q;
          dists_d[idx_q[IDX_W-1:0]] = acc_q;
          if (count_q != CNT_W'(KEPT_MAX)) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        res_valid_d = 1'b1;
        slot_d      = SLOT_W'(idx_q);
        kept_d      = rd_id;
        dist_out_d  = DIST_OUT_W'(rd_dist);
        last_d      = (idx_inc == count_q);
        if (idx_inc == count_q) begin
          count_d = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, viewer registers and registered result outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      axis_q      <= AXIS_X;
      res_valid_q <= 1'b0;
      slot_q      <= '0;
      kept_q      <= '0;
      dist_out_q  <= '0;
      last_q      <= 1'b0;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      axis_q      <= axis_d;
      res_valid_q <= res_valid_d;
      slot_q      <= slot_d;
      kept_q      <= kept_d;
      dist_out_q  <= dist_out_d;
      last_q      <= last_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      vz_q        <= vz_d;
    end
  end

  // Datapath and list storage.
  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    mag_q   <= mag_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    ids_q   <= ids_d;
    dists_q <= dists_d;
  end

  // The list never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(KEPT_MAX))
  else $error("entry count exceeds list depth");

  // Results only come out of a flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_FLUSH))
  else $error("result strobe outside a flush");

  // The last result of a flush leaves the list empty and is not followed by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_run_o) |-> (count_q == '0 && !busy))
  else $error("flush did not end cleanly");

  // An accepted offer always occupies the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_OFFER) |=> (busy && state_q == ST_DIFF))
  else $error("offer transaction not started");

endmodule : nearest_k_light_select

`default_nettype wire
